// ===== hdl/lcdrd_pkg.sv =====
`timescale 1ns / 1ps

package lcdrd_pkg;

  // opcodes of the input word
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ANN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // read form that returns the annunciators instead of digits
  localparam logic [3:0] SUB_ANN_READ = 4'd5;

  // number of nibbles in a data word
  localparam int unsigned NIBBLES = 12;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // register group, digit count and direction of one access form
  typedef struct packed {
    logic       en_a;
    logic       en_b;
    logic       en_c;
    logic [3:0] cnt;
    logic       left;
  } form_t;

  // per-cycle control of the digit cells
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic take_low;
  } cell_ctrl_t;

  // sequencer to chain: shift control and digits to insert
  typedef struct packed {
    cell_ctrl_t chain;
    logic       is_write;
    logic [3:0] wv_a;
    logic [3:0] wv_b;
    logic       wv_c;
  } seq_ctrl_t;

  // one digit of each register, as seen at an end of the chain
  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic       c;
  } tap_t;

  function automatic form_t mk_form(input logic a, input logic b, input logic c,
                                    input logic [3:0] cnt, input logic left);
    form_t f;
    f.en_a = a;
    f.en_b = b;
    f.en_c = c;
    f.cnt  = cnt;
    f.left = left;
    return f;
  endfunction

  // read forms
  function automatic form_t read_form(input logic [3:0] sub);
    form_t f;
    case (sub)
      4'd0:    f = mk_form(1'b1, 1'b0, 1'b0, 4'd12, 1'b1);
      4'd1:    f = mk_form(1'b0, 1'b1, 1'b0, 4'd12, 1'b1);
      4'd2:    f = mk_form(1'b0, 1'b0, 1'b1, 4'd12, 1'b1);
      4'd3:    f = mk_form(1'b1, 1'b1, 1'b0, 4'd6,  1'b1);
      4'd4:    f = mk_form(1'b1, 1'b1, 1'b1, 4'd4,  1'b1);
      4'd6:    f = mk_form(1'b0, 1'b0, 1'b1, 4'd1,  1'b1);
      4'd7:    f = mk_form(1'b1, 1'b0, 1'b0, 4'd1,  1'b0);
      4'd8:    f = mk_form(1'b0, 1'b1, 1'b0, 4'd1,  1'b0);
      4'd9:    f = mk_form(1'b0, 1'b0, 1'b1, 4'd1,  1'b0);
      4'd10:   f = mk_form(1'b1, 1'b0, 1'b0, 4'd1,  1'b1);
      4'd11:   f = mk_form(1'b0, 1'b1, 1'b0, 4'd1,  1'b1);
      4'd12:   f = mk_form(1'b1, 1'b1, 1'b0, 4'd1,  1'b0);
      4'd13:   f = mk_form(1'b1, 1'b1, 1'b0, 4'd1,  1'b1);
      4'd14:   f = mk_form(1'b1, 1'b1, 1'b1, 4'd1,  1'b0);
      4'd15:   f = mk_form(1'b1, 1'b1, 1'b1, 4'd1,  1'b1);
      default: f = mk_form(1'b0, 1'b0, 1'b0, 4'd0,  1'b0);
    endcase
    return f;
  endfunction

  // write forms
  function automatic form_t write_form(input logic [3:0] sub);
    form_t f;
    case (sub)
      4'd0:    f = mk_form(1'b1, 1'b0, 1'b0, 4'd12, 1'b1);
      4'd1:    f = mk_form(1'b0, 1'b1, 1'b0, 4'd12, 1'b1);
      4'd2:    f = mk_form(1'b0, 1'b0, 1'b1, 4'd12, 1'b1);
      4'd3:    f = mk_form(1'b1, 1'b1, 1'b0, 4'd6,  1'b1);
      4'd4:    f = mk_form(1'b1, 1'b1, 1'b1, 4'd4,  1'b1);
      4'd5:    f = mk_form(1'b1, 1'b1, 1'b0, 4'd6,  1'b0);
      4'd6:    f = mk_form(1'b1, 1'b1, 1'b1, 4'd4,  1'b0);
      4'd7:    f = mk_form(1'b1, 1'b0, 1'b0, 4'd1,  1'b1);
      4'd8:    f = mk_form(1'b0, 1'b1, 1'b0, 4'd1,  1'b1);
      4'd9:    f = mk_form(1'b0, 1'b0, 1'b1, 4'd1,  1'b1);
      4'd10:   f = mk_form(1'b1, 1'b0, 1'b0, 4'd1,  1'b0);
      4'd11:   f = mk_form(1'b0, 1'b1, 1'b0, 4'd1,  1'b0);
      4'd12:   f = mk_form(1'b1, 1'b1, 1'b0, 4'd1,  1'b1);
      4'd13:   f = mk_form(1'b1, 1'b1, 1'b0, 4'd1,  1'b0);
      4'd14:   f = mk_form(1'b1, 1'b1, 1'b1, 4'd1,  1'b1);
      default: f = mk_form(1'b1, 1'b1, 1'b1, 4'd1,  1'b0);
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/lcdrd_cell.sv =====
`timescale 1ns / 1ps

module lcdrd_cell
  import lcdrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  tap_t       lo,
  input  tap_t       hi,
  output tap_t       q
);

  tap_t q_next;

  // take the neighbor below when shifting up, the one above when shifting down
  always_comb begin
    q_next = q;
    if (ctrl.en_a) q_next.a = ctrl.take_low ? lo.a : hi.a;
    if (ctrl.en_b) q_next.b = ctrl.take_low ? lo.b : hi.b;
    if (ctrl.en_c) q_next.c = ctrl.take_low ? lo.c : hi.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== hdl/lcdrd_seq.sv =====
`timescale 1ns / 1ps

module lcdrd_seq
  import lcdrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  sub_op,
  input  logic [47:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] read_data,
  input  tap_t        top_tap,
  input  tap_t        bot_tap,
  output seq_ctrl_t   ctrl
);

  state_t      state, state_next;
  form_t       form;
  form_t       new_form;
  logic        is_write;
  logic [3:0]  cnt;
  logic [3:0]  pos;
  logic [47:0] wsh;
  logic [47:0] acc;
  logic [11:0] annunciators;

  logic        accept;
  logic        running;
  logic        deliver;
  logic [1:0]  n_grp;
  logic [3:0]  pa, pb, pc;
  logic [3:0]  va, vb, vc;
  logic [3:0]  wc_nib;

  assign accept  = in_valid && in_ready;
  assign running = (state == ST_RUN);
  assign deliver = (state == ST_HOLD) && (!out_valid || out_ready);

  // form of the word being offered
  assign new_form = (opcode == OP_WRITE) ? write_form(sub_op) : read_form(sub_op);

  // nibble positions of this step, groups in a, b, c order
  assign n_grp = 2'(form.en_a) + 2'(form.en_b) + 2'(form.en_c);
  assign pa    = pos;
  assign pb    = pos + 4'(form.en_a);
  assign pc    = pos + 4'(form.en_a) + 4'(form.en_b);

  // digits leaving the chain on a read
  assign va = form.left ? top_tap.a : bot_tap.a;
  assign vb = form.left ? top_tap.b : bot_tap.b;
  assign vc = {3'b000, form.left ? top_tap.c : bot_tap.c};

  // digit for c sits after those used by a and b
  always_comb begin
    case ({1'b0, form.en_a} + {1'b0, form.en_b})
      2'd0:    wc_nib = wsh[3:0];
      2'd1:    wc_nib = wsh[7:4];
      default: wc_nib = wsh[11:8];
    endcase
  end

  // next state and chain control
  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    ctrl.chain.en_a     = running && form.en_a;
    ctrl.chain.en_b     = running && form.en_b;
    ctrl.chain.en_c     = running && form.en_c;
    ctrl.chain.take_low = is_write ? !form.left : form.left;
    ctrl.is_write       = is_write;
    ctrl.wv_a           = wsh[3:0];
    ctrl.wv_b           = form.en_a ? wsh[7:4] : wsh[3:0];
    ctrl.wv_c           = wc_nib[0];
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_READ) begin
          state_next = (sub_op == SUB_ANN_READ) ? ST_HOLD : ST_RUN;
        end else if (accept && opcode == OP_WRITE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == 4'd1) state_next = is_write ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (deliver) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // annunciator register
  always_ff @(posedge clk) begin
    if (rst) begin
      annunciators <= '0;
    end else if (accept && opcode == OP_ANN) begin
      annunciators <= write_data[11:0];
    end
  end

  // word setup at accept, then one step per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      is_write <= (opcode == OP_WRITE);
      form     <= new_form;
      cnt      <= new_form.cnt;
      pos      <= '0;
      wsh      <= write_data;
      acc      <= (sub_op == SUB_ANN_READ) ? {36'd0, annunciators} : '0;
    end else if (running) begin
      cnt <= cnt - 4'd1;
      pos <= pos + 4'(n_grp);
      case (n_grp)
        2'd1:    wsh <= {4'd0, wsh[47:4]};
        2'd2:    wsh <= {8'd0, wsh[47:8]};
        default: wsh <= {12'd0, wsh[47:12]};
      endcase
      if (!is_write) begin
        if (form.en_a && pa < 4'(NIBBLES)) acc[{pa, 2'b00} +: 4] <= va;
        if (form.en_b && pb < 4'(NIBBLES)) acc[{pb, 2'b00} +: 4] <= vb;
        if (form.en_c && pc < 4'(NIBBLES)) acc[{pc, 2'b00} +: 4] <= vc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) read_data <= acc;
  end

endmodule

// ===== hdl/lcd_rotating_digit_registers.sv =====
`timescale 1ns / 1ps

// Display digit registers with rotating access.
// Input channel (in_valid/in_ready) carries one word: opcode, sub_op and
// write_data. opcode read returns one read_data word on the output channel
// (out_valid/out_ready); digit writes, annunciator writes and the unused
// opcode return nothing.
// The digits live in a row of DIGITS cells, each holding one digit of A, B
// and C; every step of an access shifts the selected registers by one cell,
// with the chain ends wrapping around on reads and taking the new digit on
// writes.
// Sequencing: a digit access is accepted, then runs one step per cycle
// (1, 4, 6 or 12 steps); a read then waits in the hold state to load the
// output register. Annunciator writes finish on accept; annunciator reads go straight to the hold state.
// Throughput: one word at a time; in_ready is high only while the
// sequencer is idle. A finished read waits in the sequencer while a
// previous result still sits in the output register, so a stalled receiver
// holds off further input after at most one pending result.
// Reset clears all digits, the annunciators, the sequencer state and out_valid.
module lcd_rotating_digit_registers
  import lcdrd_pkg::*;
#(
  parameter int DIGITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  sub_op,
  input  logic [47:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] read_data
);

  seq_ctrl_t ctrl;
  tap_t      cell_q [DIGITS];
  tap_t      wrap_lo;
  tap_t      wrap_hi;
  tap_t      wv;

  // sequencer
  lcdrd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .sub_op     (sub_op),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .top_tap    (cell_q[DIGITS-1]),
    .bot_tap    (cell_q[0]),
    .ctrl       (ctrl)
  );

  // chain ends: wrap on reads, new digit on writes
  assign wv.a    = ctrl.wv_a;
  assign wv.b    = ctrl.wv_b;
  assign wv.c    = ctrl.wv_c;
  assign wrap_lo = ctrl.is_write ? wv : cell_q[DIGITS-1];
  assign wrap_hi = ctrl.is_write ? wv : cell_q[0];

  // row of digit cells
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    tap_t lo;
    tap_t hi;
    if (i == 0) begin : g_lo_end
      assign lo = wrap_lo;
    end else begin : g_lo_mid
      assign lo = cell_q[i-1];
    end
    if (i == DIGITS - 1) begin : g_hi_end
      assign hi = wrap_hi;
    end else begin : g_hi_mid
      assign hi = cell_q[i+1];
    end
    lcdrd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl.chain),
      .lo   (lo),
      .hi   (hi),
      .q    (cell_q[i])
    );
  end

endmodule

// ===== tb/sv/tb_lcd_rotating_digit_registers.sv =====
`timescale 1ns / 1ps

module tb_lcd_rotating_digit_registers;
  import lcdrd_pkg::*;

  localparam int DIGITS = 12;
  localparam int RANDOM_WORDS = 1850;

  // digit rows of the display model, also the bit of each row in a group mask
  localparam int ROW_A = 0;
  localparam int ROW_B = 1;
  localparam int ROW_C = 2;

  // read forms by sub_op, entry 15 first: group mask, digit count, left flag
  localparam logic [15:0][2:0] RD_GRP = {
    3'b111, 3'b111, 3'b011, 3'b011, 3'b010, 3'b001, 3'b100, 3'b010,
    3'b001, 3'b100, 3'b000, 3'b111, 3'b011, 3'b100, 3'b010, 3'b001};
  localparam logic [15:0][3:0] RD_CNT = {
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd0, 4'd4, 4'd6, 4'd12, 4'd12, 4'd12};
  localparam logic [15:0] RD_LEFT = 16'b1010_1100_0101_1111;

  // write forms by sub_op, same layout
  localparam logic [15:0][2:0] WR_GRP = {
    3'b111, 3'b111, 3'b011, 3'b011, 3'b010, 3'b001, 3'b100, 3'b010,
    3'b001, 3'b111, 3'b011, 3'b111, 3'b011, 3'b100, 3'b010, 3'b001};
  localparam logic [15:0][3:0] WR_CNT = {
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd4, 4'd6, 4'd4, 4'd6, 4'd12, 4'd12, 4'd12};
  localparam logic [15:0] WR_LEFT = 16'b0101_0011_1001_1111;

  localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    opcode_t     op;
    logic [3:0]  sub;
    logic [47:0] data;
    int unsigned gap;
    bit          drain;
  } display_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = 2'd0;
  logic [3:0]  sub_op = 4'd0;
  logic [47:0] write_data = 48'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] read_data;

  display_word_t words_to_send[$];
  logic [47:0]   read_words_due[$];
  display_word_t head_word;
  int unsigned   words_queued = 0;
  int unsigned   words_taken = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_left = 0;
  int unsigned   rx_cycles = 0;
  int unsigned   mismatch_count = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;

  // display model state
  logic [3:0]  disp_digits [3][DIGITS];
  logic [11:0] ann_bits;

  lcd_rotating_digit_registers #(
    .DIGITS(DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .sub_op(sub_op),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // top entry wraps to 0, the rest move up one
  task automatic roll_up(input int row);
    logic [3:0] t;
    int i;
    t = disp_digits[row][DIGITS-1];
    for (i = DIGITS - 1; i > 0; i--) disp_digits[row][i] = disp_digits[row][i-1];
    disp_digits[row][0] = t;
  endtask

  // entry 0 wraps to the top, the rest move down one
  task automatic roll_down(input int row);
    logic [3:0] t;
    int i;
    t = disp_digits[row][0];
    for (i = 0; i < DIGITS - 1; i++) disp_digits[row][i] = disp_digits[row][i+1];
    disp_digits[row][DIGITS-1] = t;
  endtask

  task automatic clear_display_model();
    int r;
    int i;
    for (r = 0; r < 3; r++)
      for (i = 0; i < DIGITS; i++) disp_digits[r][i] = 4'd0;
    ann_bits = 12'd0;
  endtask

  // update the display model for one accepted word, queue the read word it yields
  task automatic apply_display_word(input opcode_t op, input logic [3:0] sub,
                                    input logic [47:0] data);
    logic [2:0]  grp;
    logic [3:0]  cnt;
    logic        left;
    logic [47:0] acc;
    logic [3:0]  v;
    int          pos;
    int          k;
    int          g;
    acc = 48'd0;
    pos = 0;
    case (op)
      OP_READ: begin
        if (sub == SUB_ANN_READ) begin
          acc[11:0] = ann_bits;
        end else begin
          grp = RD_GRP[sub];
          cnt = RD_CNT[sub];
          left = RD_LEFT[sub];
          for (k = 0; k < cnt; k++)
            for (g = 0; g < 3; g++)
              if (grp[g]) begin
                if (left) begin
                  v = disp_digits[g][DIGITS-1];
                  roll_up(g);
                end else begin
                  v = disp_digits[g][0];
                  roll_down(g);
                end
                if (g == ROW_C) v = v & 4'h1;
                acc[4*pos +: 4] = v;
                pos++;
              end
        end
        read_words_due.push_back(acc);
      end
      OP_WRITE: begin
        grp = WR_GRP[sub];
        cnt = WR_CNT[sub];
        left = WR_LEFT[sub];
        for (k = 0; k < cnt; k++)
          for (g = 0; g < 3; g++)
            if (grp[g]) begin
              v = data[4*pos +: 4];
              if (g == ROW_C) v = v & 4'h1;
              if (left) begin
                roll_down(g);
                disp_digits[g][DIGITS-1] = v;
              end else begin
                roll_up(g);
                disp_digits[g][0] = v;
              end
              pos++;
            end
      end
      OP_ANN: ann_bits = data[11:0];
      default: ;
    endcase
  endtask

  task automatic add_word(input opcode_t op, input logic [3:0] sub,
                          input logic [47:0] data, input bit drain);
    display_word_t w;
    w.op = op;
    w.sub = sub;
    w.data = data;
    w.gap = tx_calm ? 0 : $urandom_range(0, 8);
    w.drain = drain;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  // driver: present queued words, feed accepted ones to the display model
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_cycles <= 0;
      clear_display_model();
    end else begin
      if (in_valid && in_ready) begin
        apply_display_word(opcode_t'(opcode), sub_op, write_data);
        words_taken++;
      end
      if (in_valid && !in_ready) begin
        // word still waiting for acceptance
      end else if (words_to_send.size() != 0 && idle_cycles >= words_to_send[0].gap &&
                   !(words_to_send[0].drain && read_words_due.size() != 0)) begin
        head_word = words_to_send.pop_front();
        opcode <= head_word.op;
        sub_op <= head_word.sub;
        write_data <= head_word.data;
        in_valid <= 1'b1;
        idle_cycles <= 0;
      end else begin
        in_valid <= 1'b0;
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // monitor: check read words, stall the output side at random
  always @(posedge clk) begin
    logic [47:0] want_word;
    int unsigned draw;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (out_valid && out_ready) begin
        if (read_words_due.size() == 0) begin
          $error("read_data: unexpected word, actual %h", read_data);
          mismatch_count++;
        end else begin
          want_word = read_words_due.pop_front();
          if (read_data !== want_word) begin
            $error("read_data mismatch: expected %h, actual %h", want_word, read_data);
            mismatch_count++;
          end
        end
        draw = rx_calm ? 0 : $urandom_range(0, 8);
        stall_left <= draw;
        out_ready <= (draw == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned counted;
    int unsigned r;
    opcode_t     op;
    logic [63:0] wide;
    logic [47:0] data;

    // directed: reset contents, extremes, C masking, annunciators, unused opcode
    add_word(OP_READ, 4'd0, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd0, ALL_ONES, 1'b0);
    add_word(OP_READ, 4'd0, ALL_ONES, 1'b0);
    add_word(OP_WRITE, 4'd1, 48'h0123_4567_89AB, 1'b0);
    add_word(OP_WRITE, 4'd2, ALL_ONES, 1'b0);
    add_word(OP_READ, 4'd2, 48'd0, 1'b0);
    add_word(OP_READ, 4'd1, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd6, 48'hFED_CBA_987_654, 1'b1);
    add_word(OP_READ, 4'd14, 48'd0, 1'b0);
    add_word(OP_READ, 4'd15, 48'd0, 1'b0);
    add_word(OP_READ, 4'd4, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd5, 48'h5A5_A5A_C3C_3C3, 1'b0);
    add_word(OP_READ, 4'd3, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd3, 48'h1357_9BDF_2468, 1'b0);
    add_word(OP_READ, 4'd12, 48'd0, 1'b0);
    add_word(OP_READ, 4'd13, 48'd0, 1'b0);
    add_word(OP_ANN, 4'd15, ALL_ONES, 1'b0);
    add_word(OP_READ, SUB_ANN_READ, ALL_ONES, 1'b0);
    add_word(OP_ANN, 4'd0, 48'd0, 1'b1);
    add_word(OP_READ, SUB_ANN_READ, 48'd0, 1'b0);
    add_word(OP_NONE, 4'd15, ALL_ONES, 1'b0);
    add_word(OP_READ, 4'd9, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd9, ALL_ONES, 1'b0);
    add_word(OP_READ, 4'd6, 48'd0, 1'b0);
    add_word(OP_WRITE, 4'd15, 48'h0000_0000_0ABC, 1'b0);

    // random words in segments, some with no sender gaps
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if (counted % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_READ;
      else if (r < 85) op = OP_WRITE;
      else if (r < 95) op = OP_ANN;
      else op = OP_NONE;
      r = $urandom_range(0, 9);
      wide = {$urandom, $urandom};
      if (r == 0) data = ALL_ONES;
      else if (r == 1) data = 48'd0;
      else data = wide[47:0];
      add_word(op, 4'($urandom_range(0, 15)), data, $urandom_range(0, 63) == 0);
      counted++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (words_taken < words_queued) @(posedge clk);
    while (read_words_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && read_words_due.size() == 0) begin
      $display("lcd_rotating_digit_registers verification clean");
    end else begin
      $display("lcd_rotating_digit_registers verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("lcd_rotating_digit_registers verification failed");
    $finish;
  end

endmodule
